// File: rtl/core/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// No dependencies; every other file of the block imports this package.
package utf8d_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00003F;

    // One input beat: a raw byte and the end-of-string mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } byte_beat_t;

    // One output beat: a decoded code point with its flags.
    typedef struct packed {
        logic [20:0] code_point;
        logic        bad_sequence;
        logic        final_result;
    } cp_beat_t;

    // Everything one byte produces: one result, or two when 'two' is set.
    typedef struct packed {
        logic     two;
        cp_beat_t first;
        cp_beat_t second;
    } decode_rec_t;

endpackage

// File: rtl/core/utf8d_front.sv
// Front end of the decoder: accepts bytes, tracks the open sequence and
// builds one queue record per byte that yields results. Uses utf8d_pkg.
module utf8d_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    input  utf8d_pkg::byte_beat_t   byte_data,
    output logic                    byte_stall,
    input  logic                    queue_full,
    output logic                    push,
    output utf8d_pkg::decode_rec_t  rec
);
    import utf8d_pkg::*;

    logic [1:0]  remaining_reg;
    logic [1:0]  remaining_next;
    logic [20:0] partial_reg;
    logic [20:0] partial_next;

    logic        accept;
    logic        produce;
    logic [7:0]  b;
    logic        last;
    logic        cont;
    logic [20:0] cont_part;
    logic        lead_emit;
    cp_beat_t    lead_res;
    cp_beat_t    err_res;
    logic [1:0]  lead_rem;
    logic [20:0] lead_part;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign push       = produce && accept;

    // Decode the byte as if it opened a new sequence.
    always_comb
    begin
        b         = byte_data.in_byte;
        last      = byte_data.string_end;
        cont      = (b[7:6] == 2'b10);
        cont_part = {partial_reg[14:0], b[5:0]};

        err_res              = '0;
        err_res.code_point   = REPLACEMENT_CP;
        err_res.bad_sequence = 1'b1;

        lead_emit = 1'b0;
        lead_res  = '0;
        lead_rem  = 2'd0;
        lead_part = '0;
        priority if (!b[7])
        begin
            lead_emit           = 1'b1;
            lead_res.code_point = {13'd0, b};
        end
        else if (cont || (b[7:3] == 5'b11111))
        begin
            lead_emit = 1'b1;
            lead_res  = err_res;
        end
        else if (!b[5])
        begin
            lead_rem  = 2'd1;
            lead_part = {16'd0, b[4:0]};
        end
        else if (!b[4])
        begin
            lead_rem  = 2'd2;
            lead_part = {17'd0, b[3:0]};
        end
        else
        begin
            lead_rem  = 2'd3;
            lead_part = {18'd0, b[2:0]};
        end

        // A lead byte that ends the string leaves the sequence truncated.
        if ((lead_rem != 2'd0) && last)
        begin
            lead_emit = 1'b1;
            lead_res  = err_res;
            lead_rem  = 2'd0;
            lead_part = '0;
        end
    end

    // Combine with the open sequence and build the record.
    always_comb
    begin
        produce        = 1'b0;
        rec            = '0;
        remaining_next = remaining_reg;
        partial_next   = partial_reg;

        priority if ((remaining_reg != 2'd0) && cont)
        begin
            remaining_next = remaining_reg - 2'd1;
            partial_next   = cont_part;
            if (remaining_next == 2'd0)
            begin
                produce              = 1'b1;
                rec.first.code_point = cont_part;
                partial_next         = '0;
            end
            else if (last)
            begin
                produce        = 1'b1;
                rec.first      = err_res;
                remaining_next = 2'd0;
                partial_next   = '0;
            end
        end
        else if (remaining_reg != 2'd0)
        begin
            // Interrupted sequence: flag it, then treat the byte as a lead.
            produce        = 1'b1;
            rec.first      = err_res;
            rec.two        = lead_emit;
            rec.second     = lead_res;
            remaining_next = lead_rem;
            partial_next   = lead_part;
        end
        else
        begin
            produce        = lead_emit;
            rec.first      = lead_res;
            remaining_next = lead_rem;
            partial_next   = lead_part;
        end

        if (last)
        begin
            if (rec.two)
            begin
                rec.second.final_result = 1'b1;
            end
            else
            begin
                rec.first.final_result = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 2'd0;
            partial_reg   <= '0;
        end
        else if (accept)
        begin
            remaining_reg <= remaining_next;
            partial_reg   <= partial_next;
        end
    end

endmodule

// File: rtl/core/utf8d_queue.sv
// Short record queue between the decoder front and back ends.
// Uses utf8d_pkg for the record type.
module utf8d_queue #(
    parameter int Depth = utf8d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  utf8d_pkg::decode_rec_t  wr_rec,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output utf8d_pkg::decode_rec_t  head
);
    import utf8d_pkg::*;

    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    decode_rec_t        slots [Depth];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_next;
    logic [CountW-1:0]  count_reg;
    logic [CountW-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CountW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/utf8d_back.sv
// Back end of the decoder: drains queue records and hands out one result
// beat per cycle while cp_stall is low, from an output register. Uses utf8d_pkg.
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  utf8d_pkg::decode_rec_t  head,
    output logic                    pop,
    output logic                    cp_valid,
    output utf8d_pkg::cp_beat_t     cp_data,
    input  logic                    cp_stall
);
    import utf8d_pkg::*;

    logic      out_valid_reg;
    cp_beat_t  out_data_reg;
    logic      hold_valid_reg;
    cp_beat_t  hold_data_reg;
    logic      load;

    assign load     = !out_valid_reg || !cp_stall;
    assign pop      = load && !hold_valid_reg && head_valid;
    assign cp_valid = out_valid_reg;
    assign cp_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (hold_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= head_valid;
                hold_valid_reg <= head_valid && head.two;
            end
        end
    end

    // Payload: hold the second result of a record until the first is taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (hold_valid_reg)
            begin
                out_data_reg <= hold_data_reg;
            end
            else if (head_valid)
            begin
                out_data_reg  <= head.first;
                hold_data_reg <= head.second;
            end
        end
    end

endmodule

// File: rtl/core/utf8_to_utf32_decoder.sv
// UTF-8 to UTF-32 stream decoder. Takes one byte beat per cycle, unless byte_stall
// holds it, and returns 21-bit code points; malformed input yields a beat with
// bad_sequence set and code point 0x3F, and decoding carries on. A byte that
// interrupts an open sequence can yield two beats (when it is itself a whole
// byte, an invalid lead or the end of the string), and the output register then
// hands them out one after the other. The first result of a byte is registered
// in the queue and then in the output register before it is presented.
// A record queue of QueueDepth entries sits between the byte front end and the
// output stage, so byte_stall rises only once the queue is full behind a busy
// or stalled output.
// Built on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
module utf8_to_utf32_decoder #(
    parameter int QueueDepth = utf8d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  utf8d_pkg::byte_beat_t  byte_data,
    output logic                   byte_stall,
    output logic                   cp_valid,
    output utf8d_pkg::cp_beat_t    cp_data,
    input  logic                   cp_stall
);
    import utf8d_pkg::*;

    logic         push;
    decode_rec_t  wr_rec;
    logic         full;
    logic         pop;
    logic         head_valid;
    decode_rec_t  head;

    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_stall (byte_stall),
        .queue_full (full),
        .push       (push),
        .rec        (wr_rec)
    );

    utf8d_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_rec     (wr_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    utf8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .cp_valid   (cp_valid),
        .cp_data    (cp_data),
        .cp_stall   (cp_stall)
    );

endmodule

// File: rtl/core/utf8d_checker.sv
// Port-level checks for the UTF-8 decoder, bound to the top level.
// Uses utf8d_pkg for the beat types.
module utf8d_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_valid,
    input utf8d_pkg::byte_beat_t  byte_data,
    input logic                   byte_stall,
    input logic                   cp_valid,
    input utf8d_pkg::cp_beat_t    cp_data,
    input logic                   cp_stall
);
    import utf8d_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_stall |=> cp_valid && $stable(cp_data))
        else $error("result beat changed while stalled");

    // Error beats always carry the replacement character.
    a_bad_cp: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_data.bad_sequence |-> cp_data.code_point == REPLACEMENT_CP)
        else $error("error beat without replacement code point");

    // The byte side only backs up behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> cp_valid)
        else $error("byte side stalled with no result pending");

    // A byte with the end mark that is taken in a free pipe yields a final beat.
    a_final_seen: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && byte_data.string_end && !cp_valid
        |-> ##2 cp_valid)
        else $error("final byte produced no result");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_stall (byte_stall),
    .cp_valid   (cp_valid),
    .cp_data    (cp_data),
    .cp_stall   (cp_stall)
);

// File: bench/utf8_to_utf32_decoder_test.sv
// Self-checking bench for utf8_to_utf32_decoder: directed byte strings, then random text.
// Predicts code point beats from its own decoder model; needs utf8d_pkg and the RTL.
`timescale 1ns / 1ps

module utf8_to_utf32_decoder_test;
    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 470;

    localparam logic [7:0] LEAD2_MIN    = 8'hC0;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD_BAD_MIN = 8'hF8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    byte_beat_t byte_data = '0;
    logic       byte_stall;
    logic       cp_valid;
    cp_beat_t   cp_data;
    logic       cp_stall = 1'b0;

    // decoder model state
    logic [1:0]  cont_left = '0;
    logic [20:0] cp_accum = '0;

    cp_beat_t expected_cps[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       bytes_sent = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    utf8_to_utf32_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_stall (byte_stall),
        .cp_valid   (cp_valid),
        .cp_data    (cp_data),
        .cp_stall   (cp_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        cp_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic void push_cp(input logic [20:0] cp, input logic bad);
        cp_beat_t beat;
        beat.code_point   = cp;
        beat.bad_sequence = bad;
        beat.final_result = 1'b0;
        expected_cps.push_back(beat);
    endfunction

    function automatic void decode_lead(input logic [7:0] b, input logic last);
        if (b < 8'h80)
            push_cp({13'd0, b}, 1'b0);
        else if (b < LEAD2_MIN || b >= LEAD_BAD_MIN)
            push_cp(REPLACEMENT_CP, 1'b1);
        else
        begin
            if (b < LEAD3_MIN)
            begin
                cp_accum  = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end
            else if (b < LEAD4_MIN)
            begin
                cp_accum  = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end
            else
            begin
                cp_accum  = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
            // a lead on the final byte can never complete
            if (last)
            begin
                cont_left = '0;
                cp_accum  = '0;
                push_cp(REPLACEMENT_CP, 1'b1);
            end
        end
    endfunction

    function automatic void decode_byte(input byte_beat_t beat);
        int       size_before;
        cp_beat_t tail;
        size_before = expected_cps.size();
        if (cont_left != 0)
        begin
            if (beat.in_byte[7:6] == 2'b10)
            begin
                cp_accum  = {cp_accum[14:0], beat.in_byte[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0)
                begin
                    push_cp(cp_accum, 1'b0);
                    cp_accum = '0;
                end
                else if (beat.string_end)
                begin
                    cont_left = '0;
                    cp_accum  = '0;
                    push_cp(REPLACEMENT_CP, 1'b1);
                end
            end
            else
            begin
                // close the open sequence, then treat the byte as a fresh lead
                cont_left = '0;
                cp_accum  = '0;
                push_cp(REPLACEMENT_CP, 1'b1);
                decode_lead(beat.in_byte, beat.string_end);
            end
        end
        else
            decode_lead(beat.in_byte, beat.string_end);

        if (beat.string_end && expected_cps.size() > size_before)
        begin
            tail = expected_cps.pop_back();
            tail.final_result = 1'b1;
            expected_cps.push_back(tail);
        end
    endfunction

    task automatic report_field(input string name, input logic [20:0] want,
                                input logic [20:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cp_beat_t want;
        if (rst_n && cp_valid && !cp_stall)
        begin
            if (expected_cps.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual 0x%0h", $time, cp_data);
                error_count++;
            end
            else
            begin
                want = expected_cps.pop_front();
                if (cp_data.code_point !== want.code_point)
                    report_field("code_point", want.code_point, cp_data.code_point);
                if (cp_data.bad_sequence !== want.bad_sequence)
                    report_field("bad_sequence", {20'd0, want.bad_sequence},
                                 {20'd0, cp_data.bad_sequence});
                if (cp_data.final_result !== want.final_result)
                    report_field("final_result", {20'd0, want.final_result},
                                 {20'd0, cp_data.final_result});
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        byte_beat_t beat;
        beat.in_byte    = b;
        beat.string_end = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= beat;
        do
            @(posedge clk);
        while (byte_stall);
        decode_byte(beat);
        bytes_sent++;
    endtask

    // Hold the sender off until every expected beat is back, then let the pipe settle.
    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Send the first 'keep' bytes of a random character of 'len' bytes.
    task automatic send_char(input int len, input int keep, input logic last);
        logic [7:0] seq [4];
        int i;
        case (len)
            1:       seq[0] = 8'($urandom_range(8'h7F));
            2:       seq[0] = LEAD2_MIN | 8'($urandom_range(8'h1F));
            3:       seq[0] = LEAD3_MIN | 8'($urandom_range(8'h0F));
            default: seq[0] = LEAD4_MIN | 8'($urandom_range(8'h07));
        endcase
        for (i = 1; i < 4; i++)
            seq[i] = 8'h80 | 8'($urandom_range(8'h3F));
        for (i = 0; i < keep; i++)
            send_byte(seq[i], last && (i == keep - 1));
    endtask

    task automatic test_directed();
        logic [8:0] bytes [] = '{
            {8'h00, 1'b0}, {8'h7F, 1'b1},
            {8'hC0, 1'b0}, {8'h80, 1'b0},
            {8'hDF, 1'b0}, {8'hBF, 1'b0},
            {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
            {8'hF0, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
            {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
            {8'h80, 1'b0},                  // stray continuation
            {8'hF8, 1'b0},                  // invalid lead
            {8'hE2, 1'b0}, {8'hFF, 1'b0},   // interrupted by an invalid lead
            {8'hC3, 1'b0}, {8'h41, 1'b1},   // interrupted on the final byte
            {8'hE2, 1'b0}, {8'h82, 1'b1},   // cut short mid-sequence
            {8'hF0, 1'b1}                   // lone lead as the final byte
        };
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (bytes[i])
            send_byte(bytes[i][8:1], bytes[i][0]);
        wait_for_drain();
    endtask

    task automatic test_random_text(input int count, input int send_pct, input int recv_pct);
        int start;
        int pick;
        int len;
        start = bytes_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (bytes_sent - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                len = $urandom_range(1, 4);
                send_char(len, len, $urandom_range(7) == 0);
            end
            else if (pick < 90)
            begin
                // broken character: only its first bytes are sent, so it is left incomplete
                len = $urandom_range(2, 4);
                send_char(len, $urandom_range(1, len - 1), $urandom_range(9) == 0);
            end
            else
                send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(RANDOM_BYTES, 27, 73);
        test_random_text(RANDOM_BYTES, 73, 27);
        test_random_text(RANDOM_BYTES, 0, 0);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
